@@ sv/spr_pkg.sv @@
// ============================================================================
// spr_pkg
// Shared types, constants and the speed-to-delay map of the servo ramp.
// ============================================================================
package spr_pkg;

    localparam int ANGLE_W    = 8;
    localparam int PCT_W      = 7;
    localparam int DELAY_W    = 4;
    localparam int PROD_W     = 16;
    localparam int EST_W      = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [ANGLE_W-1:0] ANGLE_FULL   = 8'd180;
    localparam logic [PCT_W-1:0]   PCT_MAX      = 7'd100;
    localparam logic [DELAY_W-1:0] DELAY_BIAS   = 4'd5;
    localparam logic [ANGLE_W-1:0] MIN_RESET    = 8'd0;
    localparam logic [ANGLE_W-1:0] MAX_RESET    = 8'd180;

    // floor(x / 100) == (x * 5243) >> 19 for every x below 2^15.
    localparam int                 RECIP_W      = 13;
    localparam logic [RECIP_W-1:0] RECIP_100    = 13'd5243;
    localparam int                 RECIP_SHIFT  = 19;
    localparam logic [6:0]         CEIL_ADJ_100 = 7'd99;

    typedef enum logic [1:0] {
        CMD_SET  = 2'd0,
        CMD_TICK = 2'd1,
        CMD_HOME = 2'd2
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_ANGLE = 2'd0,
        CFG_MAX_ANGLE = 2'd1,
        CFG_MIRROR    = 2'd2
    } cfg_index_t;

    function automatic logic [DELAY_W-1:0] delay_for_speed(input logic [2:0] lvl);
        logic [DELAY_W-1:0] d;
        case (lvl)
            3'd7:    d = 4'd0;
            3'd6:    d = 4'd0;
            3'd5:    d = 4'd1;
            3'd4:    d = 4'd2;
            3'd3:    d = 4'd5;
            3'd2:    d = 4'd8;
            default: d = 4'd10;
        endcase
        return d;
    endfunction

endpackage

@@ sv/spr_target_map.sv @@
// ============================================================================
// spr_target_map
// Turns the scaled span (max-min)*percent into a clamped target angle.
// ============================================================================
module spr_target_map (
    input  logic signed [spr_pkg::PROD_W-1:0]  prod,
    input  logic        [spr_pkg::ANGLE_W-1:0] min_angle,
    input  logic        [spr_pkg::ANGLE_W-1:0] max_angle,
    output logic        [spr_pkg::ANGLE_W-1:0] target
);
    import spr_pkg::*;

    localparam int MAG_W = PROD_W - 1;
    localparam int SCL_W = MAG_W + RECIP_W;
    localparam int SUM_W = ANGLE_W + 3;

    logic                     neg;
    logic [PROD_W-1:0]        prod_abs;
    logic [MAG_W-1:0]         mag;
    logic [MAG_W-1:0]         mag_adj;
    logic [SCL_W-1:0]         scaled;
    logic [ANGLE_W:0]         quot;
    logic signed [SUM_W-1:0]  quot_s;
    logic signed [SUM_W-1:0]  sum;
    logic signed [SUM_W-1:0]  min_s;
    logic signed [SUM_W-1:0]  max_s;

    always_comb
    begin
        neg      = prod[PROD_W-1];
        prod_abs = neg ? PROD_W'(-prod) : PROD_W'(prod);
        mag      = prod_abs[MAG_W-1:0];
        // A negative span rounds toward minus infinity: negate the ceiling.
        mag_adj  = neg ? MAG_W'(mag + MAG_W'(CEIL_ADJ_100)) : mag;
        scaled   = SCL_W'(mag_adj) * SCL_W'(RECIP_100);
        quot     = scaled[RECIP_SHIFT +: ANGLE_W+1];
        quot_s   = neg ? -$signed(SUM_W'(quot)) : $signed(SUM_W'(quot));
        min_s    = $signed(SUM_W'(min_angle));
        max_s    = $signed(SUM_W'(max_angle));
        sum      = min_s + quot_s;
        if (sum < min_s)
        begin
            target = min_angle;
        end
        else if (sum > max_s)
        begin
            target = max_angle;
        end
        else
        begin
            target = sum[ANGLE_W-1:0];
        end
    end

endmodule

@@ sv/servo_position_ramp.sv @@
// ============================================================================
// servo_position_ramp
// Command-driven servo position ramp with slew-rate limit and mirroring.
// ============================================================================
// The block takes one command per cycle while the output is not stalled and
// returns one result per command. The first stage clamps the percent, maps
// the speed level and forms the scaled span; the second divides by 100,
// clamps the target and updates position, target, percent, step delay and
// the wait counter; the third forms the move-time estimate and the status
// flags into the output register. The whole pipeline stalls together while
// a result waits to be taken.
module servo_position_ramp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [spr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [spr_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          cmd,
    input  logic signed [7:0]                   percent,
    input  logic [2:0]                          speed_level,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [spr_pkg::ANGLE_W-1:0]         servo_angle,
    output logic [spr_pkg::ANGLE_W-1:0]         position,
    output logic [spr_pkg::ANGLE_W-1:0]         target,
    output logic [spr_pkg::EST_W-1:0]           estimate_ms,
    output logic [spr_pkg::PCT_W-1:0]           last_percent,
    output logic                                below_ninety,
    output logic                                moving
);
    import spr_pkg::*;

    // Configuration.
    logic [ANGLE_W-1:0] min_angle_reg;
    logic [ANGLE_W-1:0] max_angle_reg;
    logic               mirror_reg;

    // Pipeline control.
    logic advance;
    logic p1_valid_reg;
    logic p2_valid_reg;
    logic out_valid_reg;

    // First stage.
    logic [PCT_W-1:0]          pct_clamp;
    logic signed [ANGLE_W:0]   span;
    logic signed [PROD_W:0]    prod_full;
    cmd_t                      p1_cmd_reg;
    logic [PCT_W-1:0]          p1_pct_reg;
    logic [DELAY_W-1:0]        p1_delay_reg;
    logic signed [PROD_W-1:0]  p1_prod_reg;

    // Ramp state.
    logic [ANGLE_W-1:0] position_reg;
    logic [ANGLE_W-1:0] position_next;
    logic [ANGLE_W-1:0] target_reg;
    logic [ANGLE_W-1:0] target_next;
    logic [DELAY_W-1:0] step_delay_reg;
    logic [DELAY_W-1:0] step_delay_next;
    logic [DELAY_W-1:0] wait_count_reg;
    logic [DELAY_W-1:0] wait_count_next;
    logic [DELAY_W-1:0] wait_dec;
    logic [PCT_W-1:0]   percent_reg;
    logic [PCT_W-1:0]   percent_next;
    logic [ANGLE_W-1:0] p2_steps_reg;
    logic [ANGLE_W-1:0] p2_steps_next;
    logic [ANGLE_W-1:0] mapped_target;

    // Output stage.
    logic [DELAY_W-1:0] per_step;
    logic [EST_W-1:0]   pos_x10;
    logic [EST_W-1:0]   max_x9;
    logic [ANGLE_W-1:0] servo_angle_reg;
    logic [ANGLE_W-1:0] position_out_reg;
    logic [ANGLE_W-1:0] target_out_reg;
    logic [EST_W-1:0]   estimate_reg;
    logic [PCT_W-1:0]   last_percent_reg;
    logic               below_ninety_reg;
    logic               moving_reg;

    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_angle_reg <= MIN_RESET;
            max_angle_reg <= MAX_RESET;
            mirror_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MIN_ANGLE: min_angle_reg <= cfg_data;
                CFG_MAX_ANGLE: max_angle_reg <= cfg_data;
                CFG_MIRROR:    mirror_reg    <= cfg_data[0];
                default:       ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // First stage: clamp, speed map and the span multiply.
    // ------------------------------------------------------------------
    always_comb
    begin
        if (percent[7])
        begin
            pct_clamp = '0;
        end
        else if (percent[6:0] > PCT_MAX)
        begin
            pct_clamp = PCT_MAX;
        end
        else
        begin
            pct_clamp = percent[6:0];
        end
        span      = $signed({1'b0, max_angle_reg}) - $signed({1'b0, min_angle_reg});
        prod_full = (PROD_W+1)'(span) * $signed((PROD_W+1)'(pct_clamp));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            p1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            p1_cmd_reg   <= cmd_t'(cmd);
            p1_pct_reg   <= pct_clamp;
            p1_delay_reg <= delay_for_speed(speed_level);
            p1_prod_reg  <= prod_full[PROD_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Second stage: target mapping and the ramp state update.
    // ------------------------------------------------------------------
    spr_target_map u_target_map (
        .prod      (p1_prod_reg),
        .min_angle (min_angle_reg),
        .max_angle (max_angle_reg),
        .target    (mapped_target)
    );

    always_comb
    begin
        position_next   = position_reg;
        target_next     = target_reg;
        step_delay_next = step_delay_reg;
        wait_count_next = wait_count_reg;
        percent_next    = percent_reg;
        p2_steps_next   = '0;
        wait_dec        = (wait_count_reg != '0) ? wait_count_reg - 1'b1 : wait_count_reg;
        case (p1_cmd_reg)
            CMD_SET:
            begin
                step_delay_next = p1_delay_reg;
                percent_next    = p1_pct_reg;
                target_next     = mapped_target;
                p2_steps_next   = (position_reg > mapped_target)
                                ? position_reg - mapped_target
                                : mapped_target - position_reg;
            end
            CMD_TICK:
            begin
                wait_count_next = wait_dec;
                if (position_reg != target_reg)
                begin
                    if (step_delay_reg == '0)
                    begin
                        position_next = target_reg;
                    end
                    else if (wait_dec == '0)
                    begin
                        position_next   = (position_reg > target_reg)
                                        ? position_reg - 1'b1
                                        : position_reg + 1'b1;
                        wait_count_next = step_delay_reg;
                    end
                end
            end
            CMD_HOME:
            begin
                target_next   = min_angle_reg;
                position_next = min_angle_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p2_valid_reg   <= 1'b0;
            position_reg   <= '0;
            target_reg     <= '0;
            step_delay_reg <= '0;
            wait_count_reg <= '0;
            percent_reg    <= '0;
        end
        else if (advance)
        begin
            p2_valid_reg <= p1_valid_reg;
            if (p1_valid_reg)
            begin
                position_reg   <= position_next;
                target_reg     <= target_next;
                step_delay_reg <= step_delay_next;
                wait_count_reg <= wait_count_next;
                percent_reg    <= percent_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && p1_valid_reg)
        begin
            p2_steps_reg <= p2_steps_next;
        end
    end

    // ------------------------------------------------------------------
    // Third stage: estimate, flags and the output register. The ramp state
    // registers hold exactly the state left by the item in this stage.
    // ------------------------------------------------------------------
    always_comb
    begin
        per_step = step_delay_reg + DELAY_BIAS;
        pos_x10  = EST_W'(position_reg) * EST_W'(10);
        max_x9   = EST_W'(max_angle_reg) * EST_W'(9);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= p2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && p2_valid_reg)
        begin
            servo_angle_reg  <= mirror_reg ? ANGLE_W'(ANGLE_FULL - position_reg)
                                           : position_reg;
            position_out_reg <= position_reg;
            target_out_reg   <= target_reg;
            estimate_reg     <= EST_W'(p2_steps_reg) * EST_W'(per_step);
            last_percent_reg <= percent_reg;
            below_ninety_reg <= (pos_x10 < max_x9);
            moving_reg       <= (position_reg != target_reg);
        end
    end

    assign out_valid    = out_valid_reg;
    assign servo_angle  = servo_angle_reg;
    assign position     = position_out_reg;
    assign target       = target_out_reg;
    assign estimate_ms  = estimate_reg;
    assign last_percent = last_percent_reg;
    assign below_ninety = below_ninety_reg;
    assign moving       = moving_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_home_aligns: assert property (@(posedge clk) disable iff (!rst_n)
        advance && p1_valid_reg && p1_cmd_reg == CMD_HOME
        |=> position_reg == target_reg)
        else $error("home command did not align position and target");

    a_jump_on_zero_delay: assert property (@(posedge clk) disable iff (!rst_n)
        advance && p1_valid_reg && p1_cmd_reg == CMD_TICK && step_delay_reg == '0
        |=> position_reg == target_reg)
        else $error("tick with zero step delay did not reach the target");

    a_wait_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        wait_count_reg <= 4'd10 && step_delay_reg <= 4'd10)
        else $error("wait counter or step delay out of range");

    a_state_held_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(position_reg) && $stable(target_reg)
                     && $stable(wait_count_reg))
        else $error("ramp state changed while the pipeline was stalled");

endmodule

@@ test/servo_position_ramp_tb.sv @@
// ============================================================================
// servo_position_ramp_tb
// Self-checking bench for the servo ramp. Commands go in through a valid/ready
// channel with random gaps. A local model of the ramp predicts the status of
// every command, and each status that comes out is compared field by field
// with the oldest prediction. Runs cover directed corner cases, a long output
// hold-off and random command streams under several angle limit settings.
// ============================================================================
module servo_position_ramp_tb;
    import spr_pkg::*;

    localparam logic [1:0]  CMD_NOP       = 2'd3;
    localparam int unsigned DRAIN_LIMIT   = 5000;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned PHASE_ITEMS   = 110;

    typedef struct packed {
        logic [ANGLE_W-1:0] servo_angle;
        logic [ANGLE_W-1:0] position;
        logic [ANGLE_W-1:0] target;
        logic [EST_W-1:0]   estimate_ms;
        logic [PCT_W-1:0]   last_percent;
        logic               below_ninety;
        logic               moving;
    } servo_status_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [1:0]            cmd;
    logic signed [7:0]     percent;
    logic [2:0]            speed_level;
    logic                  out_valid;
    logic                  out_ready;
    logic [ANGLE_W-1:0]    servo_angle;
    logic [ANGLE_W-1:0]    position;
    logic [ANGLE_W-1:0]    target;
    logic [EST_W-1:0]      estimate_ms;
    logic [PCT_W-1:0]      last_percent;
    logic                  below_ninety;
    logic                  moving;

    // Local copy of the limits and of the ramp state.
    logic [ANGLE_W-1:0] lim_lo;
    logic [ANGLE_W-1:0] lim_hi;
    logic               mirror_on;
    logic [ANGLE_W-1:0] ramp_pos;
    logic [ANGLE_W-1:0] ramp_target;
    logic [DELAY_W-1:0] ramp_delay;
    logic [DELAY_W-1:0] ramp_wait;
    logic [PCT_W-1:0]   ramp_pct;

    servo_status_t status_queue[$];

    int unsigned mismatch_count;
    int unsigned items_sent;
    int unsigned results_checked;
    int unsigned limit_settings;
    bit          tx_steady;
    bit          rx_steady;
    int unsigned rx_hold;

    servo_position_ramp uut (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #800000;
        $display("Timed out waiting for the ramp to finish.");
        $display("servo_position_ramp_tb: errors");
        $finish;
    end

    function automatic int unsigned idle_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Applies one command to the local ramp state and returns the status it yields.
    function automatic servo_status_t advance_ramp(input logic [1:0] op,
            input logic [7:0] pct_raw, input logic [2:0] lvl);
        servo_status_t r;
        int pct;
        int scaled;
        int quot;
        int angle;
        int lo;
        int hi;
        int unsigned moves;
        int unsigned est;
        r = '0;
        lo = int'(lim_lo);
        hi = int'(lim_hi);
        case (op)
            CMD_SET:
            begin
                pct = int'($signed(pct_raw));
                if (pct > 100)
                    pct = 100;
                if (pct < 0)
                    pct = 0;
                case (lvl)
                    3'd7, 3'd6: ramp_delay = 4'd0;
                    3'd5:       ramp_delay = 4'd1;
                    3'd4:       ramp_delay = 4'd2;
                    3'd3:       ramp_delay = 4'd5;
                    3'd2:       ramp_delay = 4'd8;
                    default:    ramp_delay = 4'd10;
                endcase
                ramp_pct = pct[6:0];
                scaled = (hi - lo) * pct;
                // With inverted limits the span is negative and the quotient
                // rounds toward minus infinity.
                if (scaled >= 0)
                    quot = scaled / 100;
                else
                    quot = -((-scaled + 99) / 100);
                angle = lo + quot;
                if (angle < lo)
                    ramp_target = lim_lo;
                else if (angle > hi)
                    ramp_target = lim_hi;
                else
                    ramp_target = angle[7:0];
                moves = (ramp_pos > ramp_target) ? 32'(ramp_pos - ramp_target)
                                                 : 32'(ramp_target - ramp_pos);
                est = moves * (32'(ramp_delay) + 32'd5);
                r.estimate_ms = est[EST_W-1:0];
            end
            CMD_TICK:
            begin
                if (ramp_wait != 0)
                    ramp_wait = ramp_wait - 1'b1;
                if (ramp_pos != ramp_target)
                begin
                    if (ramp_delay == 0)
                        ramp_pos = ramp_target;
                    else if (ramp_wait == 0)
                    begin
                        if (ramp_pos > ramp_target)
                            ramp_pos = ramp_pos - 1'b1;
                        else
                            ramp_pos = ramp_pos + 1'b1;
                        ramp_wait = ramp_delay;
                    end
                end
            end
            CMD_HOME:
            begin
                ramp_target = lim_lo;
                ramp_pos = lim_lo;
            end
            default:
                ;
        endcase
        // The mirrored angle wraps modulo 256 when the position exceeds 180.
        r.servo_angle  = mirror_on ? ANGLE_FULL - ramp_pos : ramp_pos;
        r.position     = ramp_pos;
        r.target       = ramp_target;
        r.last_percent = ramp_pct;
        r.below_ninety = (10 * int'(ramp_pos) < 9 * int'(lim_hi));
        r.moving       = (ramp_pos != ramp_target);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        $display("MISMATCH at %0t: %s got %0d, expected %0d", $time, what, got, want);
    endtask

    // Sends one command and records its predicted status once the transfer
    // has taken place. The caller sits just after a rising edge.
    task automatic send_command(input logic [1:0] op, input logic [7:0] pct,
            input logic [2:0] lvl);
        int unsigned gap;
        gap = tx_steady ? 0 : idle_length();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        cmd         <= op;
        percent     <= pct;
        speed_level <= lvl;
        do
            @(posedge clk);
        while (!in_ready);
        status_queue.push_back(advance_ramp(op, pct, lvl));
        items_sent++;
    endtask

    task automatic wait_for_idle();
        int unsigned waited;
        in_valid <= 1'b0;
        waited = 0;
        while (status_queue.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (status_queue.size() != 0)
        begin
            report_mismatch("results never delivered", 0, status_queue.size());
            status_queue.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_limits(input logic [7:0] lo, input logic [7:0] hi,
            input logic mir);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MIN_ANGLE;
        cfg_data  <= lo;
        @(posedge clk);
        cfg_index <= CFG_MAX_ANGLE;
        cfg_data  <= hi;
        @(posedge clk);
        cfg_index <= CFG_MIRROR;
        cfg_data  <= {7'd0, mir};
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        lim_lo = lo;
        lim_hi = hi;
        mirror_on = mir;
        limit_settings++;
    endtask

    task automatic send_random_command();
        int unsigned r;
        logic [1:0] op;
        logic [7:0] pct;
        r = $urandom_range(0, 99);
        if (r < 14)
            op = CMD_SET;
        else if (r < 86)
            op = CMD_TICK;
        else if (r < 93)
            op = CMD_HOME;
        else
            op = CMD_NOP;
        if ($urandom_range(0, 3) != 0)
            pct = 8'($urandom_range(0, 100));
        else
            pct = 8'($urandom_range(0, 255));
        send_command(op, pct, 3'($urandom_range(0, 7)));
    endtask

    task automatic test_reset_state();
        send_command(CMD_TICK, 8'd0, 3'd0);
        send_command(CMD_NOP, 8'd55, 3'd7);
    endtask

    task automatic test_percent_and_speed();
        send_command(CMD_SET, 8'h7F, 3'd7);     // largest percent, no delay
        send_command(CMD_TICK, 8'd0, 3'd0);     // jumps straight to the target
        send_command(CMD_SET, 8'h80, 3'd0);     // most negative percent, slowest
        send_command(CMD_TICK, 8'd0, 3'd0);
        send_command(CMD_TICK, 8'd0, 3'd0);
        send_command(CMD_SET, 8'd100, 3'd1);
        send_command(CMD_SET, 8'd101, 3'd2);
        send_command(CMD_SET, 8'd0, 3'd3);
        send_command(CMD_SET, 8'hFF, 3'd4);
        send_command(CMD_SET, 8'd50, 3'd5);
        send_command(CMD_SET, 8'd1, 3'd6);
        send_command(CMD_TICK, 8'd0, 3'd0);
        send_command(CMD_HOME, 8'd90, 3'd2);
        wait_for_idle();
        load_limits(8'd0, 8'd180, 1'b1);
        send_command(CMD_SET, 8'd37, 3'd7);
        send_command(CMD_TICK, 8'd0, 3'd0);
    endtask

    task automatic test_special_limits();
        // Minimum above maximum.
        wait_for_idle();
        load_limits(8'd150, 8'd20, 1'b0);
        send_command(CMD_SET, 8'd50, 3'd6);
        send_command(CMD_SET, 8'd0, 3'd6);
        send_command(CMD_TICK, 8'd0, 3'd0);
        // Limits above 180, so the mirrored angle wraps.
        wait_for_idle();
        load_limits(8'd200, 8'd255, 1'b1);
        send_command(CMD_HOME, 8'd0, 3'd0);
        send_command(CMD_SET, 8'd100, 3'd5);
        send_command(CMD_TICK, 8'd0, 3'd0);
        send_command(CMD_TICK, 8'd0, 3'd0);
    endtask

    // The output side holds off long enough for the pipeline to fill and
    // stall the input while commands keep coming.
    task automatic test_backpressure();
        wait_for_idle();
        load_limits(8'd0, 8'd180, 1'b0);
        tx_steady = 1'b1;
        rx_hold = 60;
        repeat (20) send_random_command();
        tx_steady = 1'b0;
        wait_for_idle();
    endtask

    task automatic test_random_traffic();
        logic [7:0] lo;
        logic [7:0] hi;
        logic mir;
        for (int ph = 0; ph < 7; ph++)
        begin
            case (ph)
                0: begin lo = 8'd0;   hi = 8'd180; mir = 1'b0; end
                1: begin lo = 8'd0;   hi = 8'd180; mir = 1'b1; end
                2: begin lo = 8'd45;  hi = 8'd60;  mir = 1'b0; end
                3: begin lo = 8'd100; hi = 8'd100; mir = 1'b1; end
                4: begin lo = 8'd160; hi = 8'd20;  mir = 1'b1; end
                5: begin lo = 8'd170; hi = 8'd255; mir = 1'b0; end
                default:
                begin
                    lo = 8'($urandom_range(0, 180));
                    hi = 8'($urandom_range(0, 180));
                    mir = 1'($urandom_range(0, 1));
                end
            endcase
            wait_for_idle();
            load_limits(lo, hi, mir);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (i % 40 == 0)
                begin
                    tx_steady = ($urandom_range(0, 3) == 0);
                    rx_steady = ($urandom_range(0, 3) == 0);
                end
                send_random_command();
            end
            tx_steady = 1'b0;
            rx_steady = 1'b0;
        end
    endtask

    initial
    begin : drive_ready
        int unsigned stall_left;
        stall_left = 0;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_hold != 0)
            begin
                out_ready <= 1'b0;
                rx_hold = rx_hold - 1;
            end
            else if (stall_left != 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!rx_steady && $urandom_range(0, 3) == 0)
                    stall_left = idle_length();
            end
        end
    end

    // Every output transfer is matched against the oldest prediction.
    always @(posedge clk)
    begin : check_status
        servo_status_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (status_queue.size() == 0)
                report_mismatch("status with nothing pending", 1, 0);
            else
            begin
                want = status_queue.pop_front();
                results_checked++;
                if (servo_angle !== want.servo_angle)
                    report_mismatch("servo_angle", int'(servo_angle),
                                    int'(want.servo_angle));
                if (position !== want.position)
                    report_mismatch("position", int'(position), int'(want.position));
                if (target !== want.target)
                    report_mismatch("target", int'(target), int'(want.target));
                if (estimate_ms !== want.estimate_ms)
                    report_mismatch("estimate_ms", int'(estimate_ms),
                                    int'(want.estimate_ms));
                if (last_percent !== want.last_percent)
                    report_mismatch("last_percent", int'(last_percent),
                                    int'(want.last_percent));
                if (below_ninety !== want.below_ninety)
                    report_mismatch("below_ninety", int'(below_ninety),
                                    int'(want.below_ninety));
                if (moving !== want.moving)
                    report_mismatch("moving", int'(moving), int'(want.moving));
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_MIN_ANGLE;
        cfg_data = '0;
        in_valid = 1'b0;
        cmd = CMD_TICK;
        percent = '0;
        speed_level = '0;
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        rx_hold = 0;
        mismatch_count = 0;
        items_sent = 0;
        results_checked = 0;
        limit_settings = 0;
        lim_lo = MIN_RESET;
        lim_hi = MAX_RESET;
        mirror_on = 1'b0;
        ramp_pos = '0;
        ramp_target = '0;
        ramp_delay = '0;
        ramp_wait = '0;
        ramp_pct = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_percent_and_speed();
        test_special_limits();
        test_backpressure();
        test_random_traffic();
        wait_for_idle();
        $display("Covered set, tick, home and unused commands over %0d limit settings.",
                 limit_settings);
        $display("%0d commands sent, %0d statuses compared, %0d mismatches.",
                 items_sent, results_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("servo_position_ramp_tb: clean");
        else
            $display("servo_position_ramp_tb: errors");
        $finish;
    end

endmodule
